// ----- hdl/bfmpr_pkg.sv -----
// ----------------------------------------------------------------------------
// bfmpr_pkg
// Types, constants and codes shared by the burst fire period regulator.
// ----------------------------------------------------------------------------
package bfmpr_pkg;

  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned CMP_W      = TIMER_BITS + 1;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned PERIOD_W   = 12;
  localparam int unsigned TOL_W      = 8;
  localparam int unsigned DEB_W      = 4;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned ROUNDS_W   = 4;
  localparam int unsigned TICK_W     = 8;
  localparam int unsigned BLINK_W    = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [DUTY_W-1:0]     DUTY_MAX  = 7'd100;
  localparam logic [BLINK_W-1:0]    BLINK_WRAP = 17'd100000;
  localparam logic [BLINK_W-1:0]    BLINK_HALF = 17'd50000;

  localparam logic [PERIOD_W-1:0] TARGET_RST  = 12'd250;
  localparam logic [TOL_W-1:0]    TOL_RST     = 8'd10;
  localparam logic [DEB_W-1:0]    DEB_RST     = 4'd3;
  localparam logic [DUTY_W-1:0]   FLOOR_RST   = 7'd40;
  localparam logic [DUTY_W-1:0]   CEIL_RST    = 7'd60;
  localparam logic [DUTY_W-1:0]   DUTY_INIT_RST = 7'd50;
  localparam logic [ROUNDS_W-1:0] BURST_RST   = 4'd3;
  localparam logic [TICK_W-1:0]   TICK_RST    = 8'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_OPEN   = 2'd1,
    KIND_CEASE  = 2'd2,
    KIND_SAFETY = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_PERIOD = 3'd0,
    REG_TOLERANCE     = 3'd1,
    REG_DEBOUNCE      = 3'd2,
    REG_DUTY_FLOOR    = 3'd3,
    REG_DUTY_CEILING  = 3'd4,
    REG_DUTY_INITIAL  = 3'd5,
    REG_BURST_ROUNDS  = 3'd6,
    REG_TICK_MS       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] target;
    logic [TOL_W-1:0]    tol;
    logic [DEB_W-1:0]    deb_limit;
    logic [DUTY_W-1:0]   floor;
    logic [DUTY_W-1:0]   ceiling;
    logic [ROUNDS_W-1:0] burst;
    logic [TICK_W-1:0]   tick;
  } cfg_t;

  // per-transaction commands from the top level to each lane
  typedef struct packed {
    logic              run;
    logic              blink;
    logic              load;
    logic              start;
    logic              kill;
    logic              duty_wr;
    logic [DUTY_W-1:0] duty_val;
  } lane_ctrl_t;

  typedef struct packed {
    logic              rounds_nz_q;
    logic              rounds_nz_d;
    logic              jam;
    logic [DUTY_W-1:0] duty;
  } lane_stat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              feeder_on;
    logic              aim_lights_on;
    logic              is_firing;
    logic              jammed;
    logic              jam_event;
    logic              arms_request;
  } result_t;

endpackage

// ----- hdl/bfmpr_if.sv -----
// ----------------------------------------------------------------------------
// bfmpr interfaces
// Command input, result output and register write channels.
// ----------------------------------------------------------------------------
interface bfmpr_in_if;
  logic                         valid;
  logic                         ready;
  logic [bfmpr_pkg::KIND_W-1:0]  kind;
  logic                         left_spring_level;
  logic                         right_spring_level;
  logic                         arms_extended;
  logic [bfmpr_pkg::BLINK_W-1:0] blink_time_us;

  modport source (output valid, kind, left_spring_level, right_spring_level,
                  arms_extended, blink_time_us, input ready);
  modport sink   (input valid, kind, left_spring_level, right_spring_level,
                  arms_extended, blink_time_us, output ready);
endinterface

interface bfmpr_out_if;
  logic                        valid;
  logic                        ready;
  logic [bfmpr_pkg::DUTY_W-1:0] left_duty;
  logic [bfmpr_pkg::DUTY_W-1:0] right_duty;
  logic                        feeder_on;
  logic                        aim_lights_on;
  logic                        is_firing;
  logic                        jammed;
  logic                        jam_event;
  logic                        arms_request;

  modport source (output valid, left_duty, right_duty, feeder_on, aim_lights_on,
                  is_firing, jammed, jam_event, arms_request, input ready);
  modport sink   (input valid, left_duty, right_duty, feeder_on, aim_lights_on,
                  is_firing, jammed, jam_event, arms_request, output ready);
endinterface

interface bfmpr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bfmpr_pkg::CFG_IDX_W-1:0]  index;
  logic [bfmpr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/bfmpr_lane.sv -----
// ----------------------------------------------------------------------------
// bfmpr_lane
// One motor channel: round timer, spring debounce, round count and duty step.
// ----------------------------------------------------------------------------
module bfmpr_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bfmpr_pkg::cfg_t       cfg_i,
  input  bfmpr_pkg::lane_ctrl_t ctrl_i,
  input  logic                  level_i,
  output bfmpr_pkg::lane_stat_t stat_o
);
  import bfmpr_pkg::*;

  logic                  first_q, first_d;
  logic                  released_q, released_d;
  logic                  running_q, running_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [ROUNDS_W-1:0]   rounds_q, rounds_d;
  logic [DEB_W-1:0]      cnt_q, cnt_d;
  logic [DUTY_W-1:0]     duty_q, duty_d;

  logic [TIMER_BITS:0]   tsum;
  logic [TIMER_BITS-1:0] tsat;
  logic [CMP_W-1:0]      tsat_w, tgt_w, lim2_w, tol_w, late_w, early_w;
  logic [DEB_W:0]        cnt_inc;
  logic                  cnt_over, active, jam;

  always_comb begin
    tsum    = {1'b0, timer_q} + (TIMER_BITS+1)'(cfg_i.tick);
    tsat    = tsum[TIMER_BITS] ? TIMER_MAX : tsum[TIMER_BITS-1:0];
    tsat_w  = {1'b0, tsat};
    tgt_w   = CMP_W'(cfg_i.target);
    lim2_w  = CMP_W'({cfg_i.target, 1'b0});
    tol_w   = CMP_W'(cfg_i.tol);
    late_w  = tsat_w - tgt_w;
    early_w = tgt_w - tsat_w;
    cnt_inc = {1'b0, cnt_q} + (DEB_W+1)'(1);
    cnt_over = cnt_inc > {1'b0, cfg_i.deb_limit};
    active  = ctrl_i.run && (rounds_q != '0);

    first_d    = first_q;
    released_d = released_q;
    running_d  = running_q;
    timer_d    = timer_q;
    rounds_d   = rounds_q;
    cnt_d      = cnt_q;
    duty_d     = duty_q;
    jam        = 1'b0;

    if (active) begin
      timer_d = tsat;
      if (released_q != level_i) begin
        // level agrees with the accepted state: restart and watch for a jam
        cnt_d = '0;
        jam   = tsat_w > lim2_w;
      end else if (!cnt_over) begin
        cnt_d = cnt_inc[DEB_W-1:0];
      end else begin
        cnt_d      = '0;
        released_d = !released_q;
        if (!released_q) begin
          // debounced release: one round gone
          if (first_q) begin
            first_d = 1'b0;
          end else if (tsat_w > tgt_w) begin
            if (late_w > tol_w && duty_q < cfg_i.ceiling && duty_q < DUTY_MAX) begin
              duty_d = duty_q + DUTY_W'(1);
            end
          end else begin
            if (early_w > tol_w && duty_q > cfg_i.floor) begin
              duty_d = duty_q - DUTY_W'(1);
            end
          end
          timer_d  = '0;
          rounds_d = rounds_q - ROUNDS_W'(1);
          if (rounds_q == ROUNDS_W'(1)) begin
            running_d = 1'b0;
          end
        end
      end
    end
    if (ctrl_i.kill) begin
      running_d  = 1'b0;
      released_d = 1'b1;
      rounds_d   = '0;
    end
    if (ctrl_i.blink && rounds_q != '0) begin
      rounds_d = rounds_q - ROUNDS_W'(1);
    end
    if (ctrl_i.load) begin
      rounds_d = cfg_i.burst;
    end
    if (ctrl_i.start) begin
      running_d = 1'b1;
      timer_d   = '0;
      first_d   = 1'b1;
    end
    if (ctrl_i.duty_wr) begin
      duty_d = ctrl_i.duty_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= 1'b0;
      released_q <= 1'b1;
      running_q  <= 1'b0;
      timer_q    <= '0;
      rounds_q   <= '0;
      cnt_q      <= '0;
      duty_q     <= DUTY_INIT_RST;
    end else begin
      first_q    <= first_d;
      released_q <= released_d;
      running_q  <= running_d;
      timer_q    <= timer_d;
      rounds_q   <= rounds_d;
      cnt_q      <= cnt_d;
      duty_q     <= duty_d;
    end
  end

  assign stat_o.rounds_nz_q = rounds_q != '0;
  assign stat_o.rounds_nz_d = rounds_d != '0;
  assign stat_o.jam         = jam;
  assign stat_o.duty        = running_d ? duty_d : '0;

endmodule

// ----- hdl/bfmpr_merge.sv -----
// ----------------------------------------------------------------------------
// bfmpr_merge
// Combines the lane findings into the shared burst state and the result word.
// ----------------------------------------------------------------------------
module bfmpr_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [bfmpr_pkg::KIND_W-1:0]  kind_i,
  input  logic                  arms_i,
  input  logic [bfmpr_pkg::BLINK_W-1:0] blink_i,
  input  bfmpr_pkg::lane_stat_t stat_l_i,
  input  bfmpr_pkg::lane_stat_t stat_r_i,
  output bfmpr_pkg::lane_ctrl_t ctrl_o,
  output bfmpr_pkg::result_t    result_o,
  output logic                  firing_o,
  output logic                  feeder_o,
  output logic                  jammed_o
);
  import bfmpr_pkg::*;

  logic  safety_q, safety_d;
  logic  firing_q, firing_d;
  logic  jam_q, jam_d;
  logic  feeder_q, feeder_d;
  kind_e kind;
  logic  any_q, any_d, phase0, half, run, jam_any, blinking;

  always_comb begin
    kind    = kind_e'(kind_i);
    phase0  = (blink_i == '0) || (blink_i == BLINK_WRAP);
    half    = (blink_i >= BLINK_HALF) && (blink_i < BLINK_WRAP);
    any_q   = stat_l_i.rounds_nz_q || stat_r_i.rounds_nz_q;
    jam_any = stat_l_i.jam || stat_r_i.jam;
    run     = fire_i && kind == KIND_TICK && any_q && !safety_q;

    ctrl_o          = '0;
    ctrl_o.run      = run;
    ctrl_o.kill     = run && (jam_q || jam_any);
    ctrl_o.blink    = fire_i && kind == KIND_TICK && any_q && safety_q && phase0;
    ctrl_o.load     = fire_i && kind == KIND_OPEN && arms_i && (safety_q || !jam_q);
    ctrl_o.start    = fire_i && kind == KIND_OPEN && arms_i && !safety_q && !jam_q
                      && !firing_q;
    any_d = stat_l_i.rounds_nz_d || stat_r_i.rounds_nz_d;

    safety_d = safety_q;
    firing_d = firing_q;
    jam_d    = jam_q;
    feeder_d = feeder_q;
    if (run && jam_any) begin
      jam_d = 1'b1;
    end
    if (run && !any_d) begin
      firing_d = 1'b0;
      feeder_d = 1'b0;
    end
    if (ctrl_o.start) begin
      firing_d = 1'b1;
      feeder_d = 1'b1;
    end
    if (fire_i && kind == KIND_CEASE && !firing_q) begin
      jam_d = 1'b0;
    end
    if (fire_i && kind == KIND_SAFETY) begin
      safety_d = !safety_q;
    end

    blinking = safety_d && any_d;

    result_o.left_duty     = stat_l_i.duty;
    result_o.right_duty    = stat_r_i.duty;
    result_o.feeder_on     = feeder_d;
    result_o.aim_lights_on = blinking ? half : (!safety_d && arms_i);
    result_o.is_firing     = firing_d;
    result_o.jammed        = jam_d;
    result_o.jam_event     = run && jam_any;
    result_o.arms_request  = fire_i && kind == KIND_OPEN && !arms_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safety_q <= 1'b1;
      firing_q <= 1'b0;
      jam_q    <= 1'b0;
      feeder_q <= 1'b0;
    end else begin
      safety_q <= safety_d;
      firing_q <= firing_d;
      jam_q    <= jam_d;
      feeder_q <= feeder_d;
    end
  end

  assign firing_o = firing_q;
  assign feeder_o = feeder_q;
  assign jammed_o = jam_q;

endmodule

// ----- hdl/burst_fire_motor_period_regulator_top.sv -----
// ----------------------------------------------------------------------------
// burst_fire_motor_period_regulator_top
// Two-motor burst fire regulator with register port and buffered results.
// ----------------------------------------------------------------------------
// Every command transaction (tick, open fire, cease fire, toggle safety) is
// handled in the clock cycle it is accepted and yields exactly one result
// transaction, so one command can be taken every cycle. The left and right
// channels run as two identical lanes side by side; a merge stage folds their
// jam and round findings into the shared burst, safety and jam state. Results
// go into a two-entry output buffer, so input keeps flowing while one result
// waits to be taken; input ready drops only when both entries are full.
// Register writes are taken on any cycle and must only be issued while idle.
module burst_fire_motor_period_regulator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfmpr_in_if.sink    in_i,
  bfmpr_out_if.source out_o,
  bfmpr_cfg_if.sink   cfg_i
);
  import bfmpr_pkg::*;

  cfg_t       cfg_q, cfg_d;
  lane_ctrl_t ctrl, ctrl_m;
  lane_stat_t stat_l, stat_r;
  result_t    result;
  result_t    buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       fire, pop, cfg_fire, firing, feeder, jammed;
  cfg_reg_e   cfg_idx;

  assign fire     = in_i.valid && in_i.ready;
  assign pop      = out_o.valid && out_o.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign cfg_idx  = cfg_reg_e'(cfg_i.index);

  // register file
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_fire) begin
      unique case (cfg_idx)
        REG_TARGET_PERIOD: cfg_d.target    = cfg_i.data[PERIOD_W-1:0];
        REG_TOLERANCE:     cfg_d.tol       = cfg_i.data[TOL_W-1:0];
        REG_DEBOUNCE:      cfg_d.deb_limit = cfg_i.data[DEB_W-1:0];
        REG_DUTY_FLOOR:    cfg_d.floor     = cfg_i.data[DUTY_W-1:0];
        REG_DUTY_CEILING:  cfg_d.ceiling   = cfg_i.data[DUTY_W-1:0];
        REG_BURST_ROUNDS:  cfg_d.burst     = cfg_i.data[ROUNDS_W-1:0];
        REG_TICK_MS:       cfg_d.tick      = cfg_i.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target    <= TARGET_RST;
      cfg_q.tol       <= TOL_RST;
      cfg_q.deb_limit <= DEB_RST;
      cfg_q.floor     <= FLOOR_RST;
      cfg_q.ceiling   <= CEIL_RST;
      cfg_q.burst     <= BURST_RST;
      cfg_q.tick      <= TICK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  // duty preset write loads both motor duties directly
  always_comb begin
    ctrl          = ctrl_m;
    ctrl.duty_wr  = cfg_fire && cfg_idx == REG_DUTY_INITIAL;
    ctrl.duty_val = (cfg_i.data[DUTY_W-1:0] > DUTY_MAX) ? DUTY_MAX
                                                         : cfg_i.data[DUTY_W-1:0];
  end

  bfmpr_lane u_lane_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .ctrl_i  (ctrl),
    .level_i (in_i.left_spring_level),
    .stat_o  (stat_l)
  );

  bfmpr_lane u_lane_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .ctrl_i  (ctrl),
    .level_i (in_i.right_spring_level),
    .stat_o  (stat_r)
  );

  bfmpr_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .kind_i   (in_i.kind),
    .arms_i   (in_i.arms_extended),
    .blink_i  (in_i.blink_time_us),
    .stat_l_i (stat_l),
    .stat_r_i (stat_r),
    .ctrl_o   (ctrl_m),
    .result_o (result),
    .firing_o (firing),
    .feeder_o (feeder),
    .jammed_o (jammed)
  );

  // two-entry result buffer
  always_ff @(posedge clk_i) begin
    if (fire) begin
      buf_q[wr_q] <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (fire) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, fire} - {1'b0, pop};
    end
  end

  assign in_i.ready          = cnt_q != 2'd2;
  assign out_o.valid         = cnt_q != 2'd0;
  assign out_o.left_duty     = buf_q[rd_q].left_duty;
  assign out_o.right_duty    = buf_q[rd_q].right_duty;
  assign out_o.feeder_on     = buf_q[rd_q].feeder_on;
  assign out_o.aim_lights_on = buf_q[rd_q].aim_lights_on;
  assign out_o.is_firing     = buf_q[rd_q].is_firing;
  assign out_o.jammed        = buf_q[rd_q].jammed;
  assign out_o.jam_event     = buf_q[rd_q].jam_event;
  assign out_o.arms_request  = buf_q[rd_q].arms_request;

  a_jam_stops_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jammed |-> !firing)
    else $error("burst still live with jam latched");

  a_feeder_follows_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feeder == firing)
    else $error("feeder state differs from burst state");

  a_buffer_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_jam_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && result.jam_event) |=> jammed)
    else $error("jam detected but latch not set");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the burst fire motor period regulator. Commands
// are streamed in with random gaps and result back-pressure; a scoreboard
// keeps its own copy of the regulator state and compares every result
// transaction, field by field, with the result it predicts. Register sets are
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import bfmpr_pkg::*;

  typedef struct packed {
    kind_e               kind;
    logic                left_lvl;
    logic                right_lvl;
    logic                arms;
    logic [BLINK_W-1:0]  blink;
  } command_t;

  class regulator_scoreboard;
    cfg_t                cfg;
    logic [DUTY_W-1:0]   duty_init;
    bit                  safety_on, firing, jam_latch, feeder_running;
    bit                  first_round[2], spring_released[2], motor_running[2];
    logic [TIMER_BITS-1:0] round_timer[2];
    logic [ROUNDS_W-1:0] rounds_left[2];
    logic [DEB_W-1:0]    deb_count[2];
    logic [DUTY_W-1:0]   motor_duty[2];
    result_t             pending_results[$];
    int unsigned         errors;

    function new();
      errors = 0;
      cfg.target    = TARGET_RST;
      cfg.tol       = TOL_RST;
      cfg.deb_limit = DEB_RST;
      cfg.floor     = FLOOR_RST;
      cfg.ceiling   = CEIL_RST;
      cfg.burst     = BURST_RST;
      cfg.tick      = TICK_RST;
      duty_init     = DUTY_INIT_RST;
      safety_on      = 1'b1;
      firing         = 1'b0;
      jam_latch      = 1'b0;
      feeder_running = 1'b0;
      for (int c = 0; c < 2; c++) begin
        first_round[c]     = 1'b0;
        spring_released[c] = 1'b1;
        round_timer[c]     = '0;
        rounds_left[c]     = '0;
        deb_count[c]       = '0;
        motor_duty[c]      = duty_init;
        motor_running[c]   = 1'b0;
      end
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_TARGET_PERIOD: cfg.target    = d[PERIOD_W-1:0];
        REG_TOLERANCE:     cfg.tol       = d[TOL_W-1:0];
        REG_DEBOUNCE:      cfg.deb_limit = d[DEB_W-1:0];
        REG_DUTY_FLOOR:    cfg.floor     = d[DUTY_W-1:0];
        REG_DUTY_CEILING:  cfg.ceiling   = d[DUTY_W-1:0];
        REG_DUTY_INITIAL: begin
          duty_init = d[DUTY_W-1:0];
          for (int c = 0; c < 2; c++)
            motor_duty[c] = (duty_init > DUTY_MAX) ? DUTY_MAX : duty_init;
        end
        REG_BURST_ROUNDS:  cfg.burst     = d[ROUNDS_W-1:0];
        REG_TICK_MS:       cfg.tick      = d[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    // one channel on one tick, returns 1 when a jam is seen
    function bit advance_lane(int c, bit level);
      int unsigned t, lim2, nxt, tgt;
      bit jam;
      jam = 1'b0;
      if (rounds_left[c] == '0) return 1'b0;
      tgt = 32'(cfg.target);
      lim2 = 2 * tgt;
      t = 32'(round_timer[c]) + 32'(cfg.tick);
      if (t > 32'(TIMER_MAX)) t = 32'(TIMER_MAX);
      round_timer[c] = TIMER_BITS'(t);
      if (spring_released[c]) begin
        if (!level) begin
          deb_count[c] = '0;
          if (t > lim2) jam = 1'b1;
        end else begin
          nxt = 32'(deb_count[c]) + 1;
          if (nxt > 32'(cfg.deb_limit)) begin
            spring_released[c] = 1'b0;
            deb_count[c] = '0;
          end else begin
            deb_count[c] = DEB_W'(nxt);
          end
        end
      end else if (!level) begin
        nxt = 32'(deb_count[c]) + 1;
        if (nxt > 32'(cfg.deb_limit)) begin
          spring_released[c] = 1'b1;
          // the first round of a burst carries no period measurement
          if (first_round[c]) begin
            first_round[c] = 1'b0;
          end else if (t > tgt) begin
            if (t - tgt > 32'(cfg.tol) && motor_duty[c] < cfg.ceiling &&
                motor_duty[c] < DUTY_MAX)
              motor_duty[c] = motor_duty[c] + 1'b1;
          end else begin
            if (tgt - t > 32'(cfg.tol) && motor_duty[c] > cfg.floor)
              motor_duty[c] = motor_duty[c] - 1'b1;
          end
          round_timer[c] = '0;
          rounds_left[c] = rounds_left[c] - 1'b1;
          if (rounds_left[c] == '0) motor_running[c] = 1'b0;
          deb_count[c] = '0;
        end else begin
          deb_count[c] = DEB_W'(nxt);
        end
      end else begin
        deb_count[c] = '0;
        if (t > lim2) jam = 1'b1;
      end
      if (jam) jam_latch = 1'b1;
      return jam;
    endfunction

    function void note_command(command_t cmd);
      int unsigned ph;
      bit jev, areq, lights;
      result_t r;
      jev = 1'b0;
      areq = 1'b0;
      ph = 32'(cmd.blink) % 32'(BLINK_WRAP);
      case (cmd.kind)
        KIND_TICK: begin
          if (rounds_left[0] != '0 || rounds_left[1] != '0) begin
            if (safety_on) begin
              if (ph == 0)
                for (int c = 0; c < 2; c++)
                  if (rounds_left[c] != '0) rounds_left[c] = rounds_left[c] - 1'b1;
            end else begin
              if (advance_lane(0, cmd.left_lvl)) jev = 1'b1;
              if (advance_lane(1, cmd.right_lvl)) jev = 1'b1;
              if (jam_latch) begin
                feeder_running = 1'b0;
                for (int c = 0; c < 2; c++) begin
                  motor_running[c]   = 1'b0;
                  spring_released[c] = 1'b1;
                  rounds_left[c]     = '0;
                end
              end
              if (rounds_left[0] == '0 && rounds_left[1] == '0) begin
                feeder_running = 1'b0;
                firing = 1'b0;
              end
            end
          end
        end
        KIND_OPEN: begin
          if (!cmd.arms) begin
            areq = 1'b1;
          end else if (safety_on) begin
            rounds_left[0] = cfg.burst;
            rounds_left[1] = cfg.burst;
          end else if (!jam_latch) begin
            if (!firing) begin
              firing = 1'b1;
              feeder_running = 1'b1;
              for (int c = 0; c < 2; c++) begin
                motor_running[c] = 1'b1;
                round_timer[c]   = '0;
                first_round[c]   = 1'b1;
              end
            end
            rounds_left[0] = cfg.burst;
            rounds_left[1] = cfg.burst;
          end
        end
        KIND_CEASE: if (!firing) jam_latch = 1'b0;
        default: safety_on = !safety_on;
      endcase

      if (safety_on && (rounds_left[0] != '0 || rounds_left[1] != '0))
        lights = (ph >= 32'(BLINK_HALF));
      else
        lights = !safety_on && cmd.arms;

      r.left_duty     = motor_running[0] ? motor_duty[0] : '0;
      r.right_duty    = motor_running[1] ? motor_duty[1] : '0;
      r.feeder_on     = feeder_running;
      r.aim_lights_on = lights;
      r.is_firing     = firing;
      r.jammed        = jam_latch;
      r.jam_event     = jev;
      r.arms_request  = areq;
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task cmp_field(string name, logic [DUTY_W-1:0] got, logic [DUTY_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no command outstanding");
        return;
      end
      want = pending_results.pop_front();
      cmp_field("left_duty", got.left_duty, want.left_duty);
      cmp_field("right_duty", got.right_duty, want.right_duty);
      cmp_field("feeder_on", got.feeder_on, want.feeder_on);
      cmp_field("aim_lights_on", got.aim_lights_on, want.aim_lights_on);
      cmp_field("is_firing", got.is_firing, want.is_firing);
      cmp_field("jammed", got.jammed, want.jammed);
      cmp_field("jam_event", got.jam_event, want.jam_event);
      cmp_field("arms_request", got.arms_request, want.arms_request);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bfmpr_in_if  cmd_if ();
  bfmpr_out_if res_if ();
  bfmpr_cfg_if cfg_if ();

  burst_fire_motor_period_regulator_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  regulator_scoreboard sb;
  int unsigned n_sent = 0;
  bit          calm = 1'b0;
  bit          spring_lvl[2] = '{1'b0, 1'b0};
  int unsigned spring_run[2] = '{0, 0};

  // sampled mid-cycle: the values seen here are the ones taken at the next edge
  always @(negedge clk) begin
    if (rst_n && cmd_if.valid && cmd_if.ready)
      sb.note_command({kind_e'(cmd_if.kind), cmd_if.left_spring_level,
                       cmd_if.right_spring_level, cmd_if.arms_extended,
                       cmd_if.blink_time_us});
    if (rst_n && res_if.valid && res_if.ready)
      sb.check_result({res_if.left_duty, res_if.right_duty, res_if.feeder_on,
                       res_if.aim_lights_on, res_if.is_firing, res_if.jammed,
                       res_if.jam_event, res_if.arms_request});
  end

  function automatic command_t mk(kind_e k, bit l, bit r, bit a, logic [BLINK_W-1:0] b);
    command_t c;
    c.kind = k;
    c.left_lvl = l;
    c.right_lvl = r;
    c.arms = a;
    c.blink = b;
    return c;
  endfunction

  function automatic logic [BLINK_W-1:0] rand_blink();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return BLINK_HALF;
      2: return BLINK_HALF - 1'b1;
      3: return BLINK_WRAP - 1'b1;
      default: return BLINK_W'($urandom_range(int'(BLINK_WRAP) - 1, 0));
    endcase
  endfunction

  // spring sensor emulation: level runs sized around half the target period
  function automatic bit next_lvl(int c);
    int unsigned pt, lo, hi, dl, r;
    if (spring_run[c] == 0) begin
      spring_lvl[c] = !spring_lvl[c];
      pt = 32'(sb.cfg.target) / 32'(sb.cfg.tick);
      if (pt == 0) pt = 1;
      dl = 32'(sb.cfg.deb_limit);
      r = $urandom_range(19, 0);
      if (r < 2) begin
        spring_run[c] = $urandom_range((dl == 0) ? 1 : dl, 1);
      end else if (r == 2) begin
        spring_run[c] = 2 * pt + dl + $urandom_range(6, 2);
      end else begin
        lo = pt / 4;
        hi = (3 * pt) / 4 + 1;
        if (lo < dl + 1) lo = dl + 1;
        if (hi < lo) hi = lo;
        spring_run[c] = $urandom_range(hi, lo);
      end
    end
    spring_run[c]--;
    return spring_lvl[c];
  endfunction

  task automatic send(command_t c);
    cmd_if.valid              <= 1'b1;
    cmd_if.kind               <= c.kind;
    cmd_if.left_spring_level  <= c.left_lvl;
    cmd_if.right_spring_level <= c.right_lvl;
    cmd_if.arms_extended      <= c.arms;
    cmd_if.blink_time_us      <= c.blink;
    do @(negedge clk); while (!cmd_if.ready);
    @(posedge clk);
    n_sent++;
    if (!calm && $urandom_range(5, 0) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk);
    end
  endtask

  task automatic send_tick(logic [BLINK_W-1:0] b);
    bit l, r;
    l = next_lvl(0);
    r = next_lvl(1);
    send(mk(KIND_TICK, l, r, 1'($urandom_range(1, 0)), b));
  endtask

  task automatic send_kind(kind_e k, bit a);
    send(mk(k, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), a, rand_blink()));
  endtask

  task automatic quiesce();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DATA_W'(v);
    do @(negedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, CFG_DATA_W'(v));
    @(posedge clk);
  endtask

  task automatic set_regs(int unsigned tgt, int unsigned tol, int unsigned deb,
                          int unsigned flo, int unsigned ceil, int unsigned init,
                          int unsigned burst, int unsigned tick);
    quiesce();
    write_reg(REG_TARGET_PERIOD, tgt);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_DUTY_FLOOR, flo);
    write_reg(REG_DUTY_CEILING, ceil);
    write_reg(REG_DUTY_INITIAL, init);
    write_reg(REG_BURST_ROUNDS, burst);
    write_reg(REG_TICK_MS, tick);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic rand_regs();
    int unsigned tick, tgt, tol, flo, ceil, burst;
    tick = $urandom_range(8, 1);
    tgt = tick * $urandom_range(30, 5);
    tol = ($urandom_range(3, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(8, 0);
    if ($urandom_range(3, 0) == 0) begin
      flo = $urandom_range(100, 0);
      ceil = $urandom_range(100, 0);
    end else begin
      flo = $urandom_range(50, 20);
      ceil = $urandom_range(90, 50);
    end
    burst = ($urandom_range(3, 0) == 0) ? $urandom_range(15, 1) : $urandom_range(6, 1);
    set_regs(tgt, tol, $urandom_range(15, 0), flo, ceil, $urandom_range(100, 0), burst, tick);
  endtask

  task automatic live_burst();
    int unsigned cap, r;
    if (sb.safety_on) send_kind(KIND_SAFETY, 1'b1);
    send_kind(KIND_OPEN, 1'b1);
    cap = 150;
    while (sb.firing && cap > 0) begin
      r = $urandom_range(49, 0);
      if (r == 0) send_kind(KIND_OPEN, 1'($urandom_range(1, 0)));
      else if (r == 1) send_kind(KIND_CEASE, 1'($urandom_range(1, 0)));
      else send_tick(rand_blink());
      cap--;
    end
    // also clears a jam once the burst is over
    send_kind(KIND_CEASE, 1'($urandom_range(1, 0)));
  endtask

  task automatic drain_on_blink();
    int unsigned cap;
    cap = 40;
    while ((sb.rounds_left[0] != '0 || sb.rounds_left[1] != '0) && cap > 0) begin
      send_tick(($urandom_range(2, 0) == 0) ? '0 : rand_blink());
      cap--;
    end
  endtask

  task automatic run_phase(int unsigned n);
    int unsigned phase_end, e;
    phase_end = n_sent + n;
    while (n_sent < phase_end) begin
      e = $urandom_range(9, 0);
      if (e <= 5) begin
        live_burst();
      end else if (e <= 7) begin
        if (!sb.safety_on) send_kind(KIND_SAFETY, 1'($urandom_range(1, 0)));
        send_kind(KIND_OPEN, 1'b1);
        drain_on_blink();
      end else if (e == 8) begin
        // safety switched on mid-burst leaves the burst flagged as firing
        if (sb.safety_on) send_kind(KIND_SAFETY, 1'b1);
        send_kind(KIND_OPEN, 1'b1);
        repeat ($urandom_range(20, 3)) send_tick(rand_blink());
        send_kind(KIND_SAFETY, 1'($urandom_range(1, 0)));
        drain_on_blink();
        send_kind(KIND_SAFETY, 1'($urandom_range(1, 0)));
      end else begin
        repeat ($urandom_range(15, 5))
          send(mk(kind_e'($urandom_range(3, 0)), 1'($urandom_range(1, 0)),
                  1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), rand_blink()));
      end
    end
  endtask

  initial begin
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      res_if.ready <= 1'b1;
      repeat ($urandom_range(20, 1)) @(posedge clk);
      if (!calm && $urandom_range(2, 0) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(11, 1)) @(posedge clk);
      end
    end
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sb = new();
    rst_n                     <= 1'b0;
    cmd_if.valid              <= 1'b0;
    cmd_if.kind               <= KIND_TICK;
    cmd_if.left_spring_level  <= 1'b0;
    cmd_if.right_spring_level <= 1'b0;
    cmd_if.arms_extended      <= 1'b0;
    cmd_if.blink_time_us      <= '0;
    cfg_if.valid              <= 1'b0;
    cfg_if.index              <= REG_TARGET_PERIOD;
    cfg_if.data               <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, safety blink, refusals and the stuck burst
    send(mk(KIND_TICK, 1'b0, 1'b0, 1'b0, '0));
    send(mk(KIND_OPEN, 1'b1, 1'b1, 1'b0, '0));
    send(mk(KIND_OPEN, 1'b0, 1'b0, 1'b1, BLINK_HALF));
    send(mk(KIND_TICK, 1'b1, 1'b1, 1'b1, BLINK_HALF));
    send(mk(KIND_TICK, 1'b0, 1'b0, 1'b1, BLINK_HALF - 1'b1));
    send(mk(KIND_TICK, 1'b1, 1'b0, 1'b0, '0));
    send(mk(KIND_TICK, 1'b0, 1'b1, 1'b1, BLINK_WRAP - 1'b1));
    send(mk(KIND_CEASE, 1'b0, 1'b0, 1'b0, '0));
    send(mk(KIND_SAFETY, 1'b0, 1'b0, 1'b1, '0));
    send(mk(KIND_OPEN, 1'b0, 1'b0, 1'b1, '0));
    send(mk(KIND_TICK, 1'b1, 1'b1, 1'b1, BLINK_WRAP - 1'b1));
    send(mk(KIND_TICK, 1'b0, 1'b1, 1'b1, '0));
    send(mk(KIND_OPEN, 1'b0, 1'b0, 1'b1, '0));
    send(mk(KIND_OPEN, 1'b0, 1'b0, 1'b0, '0));
    send(mk(KIND_CEASE, 1'b0, 1'b0, 1'b1, '0));
    send(mk(KIND_SAFETY, 1'b0, 1'b0, 1'b1, BLINK_HALF));
    send(mk(KIND_TICK, 1'b0, 1'b0, 1'b1, '0));
    send(mk(KIND_TICK, 1'b1, 1'b1, 1'b1, '0));
    send(mk(KIND_TICK, 1'b0, 1'b0, 1'b0, '0));
    send(mk(KIND_TICK, 1'b0, 1'b0, 1'b1, BLINK_HALF + 1'b1));
    send(mk(KIND_SAFETY, 1'b0, 1'b0, 1'b1, '0));
    send(mk(KIND_OPEN, 1'b1, 1'b1, 1'b1, '0));
    send(mk(KIND_TICK, 1'b1, 1'b0, 1'b1, BLINK_W'(32'h10000)));

    set_regs(20, 2, 3, 40, 60, 50, 3, 1);
    run_phase(140);
    set_regs(1, 0, 0, 0, 100, 100, 15, 1);
    run_phase(140);
    set_regs(4095, 255, 15, 100, 100, 0, 1, 255);
    run_phase(140);
    set_regs(30, 3, 1, 45, 55, 50, 5, 2);
    run_phase(140);
    set_regs(12, 0, 2, 0, 0, 100, 2, 1);
    run_phase(140);
    rand_regs();
    run_phase(140);
    rand_regs();
    run_phase(140);
    calm = 1'b1;
    rand_regs();
    run_phase(140);

    cmd_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
